>>> rtl/gbbc_pkg.sv
`default_nettype none

package gbbc_pkg;

    localparam int COORD_W            = 13;
    localparam int DIM_W              = 14;
    localparam int GLYPH_W            = 8;
    localparam int COVER_W            = 8;
    localparam int ADDR_W             = 26;
    localparam int DATA_W             = 32;
    localparam int MODE_W             = 2;
    localparam int CFG_IDX_W          = 3;
    localparam int QUEUE_DEPTH        = 4;
    localparam int DEF_MAX_SCREEN_DIM = 4096;
    localparam int DEF_MAX_GLYPH_DIM  = 255;

    // Glyph placement and screen setup, sizes already capped
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [GLYPH_W-1:0]        cols;
        logic [GLYPH_W-1:0]        rows;
        logic [DIM_W-1:0]          xres;
        logic [DIM_W-1:0]          yres;
        logic [MODE_W-1:0]         mode;
        logic [DATA_W-1:0]         color;
    } clip_cfg_t;

    // One on-screen pixel waiting to be written
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pix_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

>>> rtl/gbbc_front.sv
`default_nettype none

module gbbc_front
    import gbbc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire clip_cfg_t          cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [COVER_W-1:0] coverage,
    input  wire q_status_t          q_stat,
    output logic                    push,
    output pix_t                    push_data
);

    logic [GLYPH_W-1:0] col_reg, col_next;
    logic [GLYPH_W-1:0] row_reg, row_next;
    logic               accept;
    logic [COORD_W:0]   x_pos;
    logic [COORD_W:0]   y_pos;
    logic               on_x;
    logic               on_y;
    logic [GLYPH_W:0]   col_inc;
    logic [GLYPH_W:0]   row_inc;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;

    // Screen position, one extra bit to carry the sign
    assign x_pos = {cfg.left[COORD_W-1], cfg.left}
                   + {{(COORD_W+1-GLYPH_W){1'b0}}, col_reg};
    assign y_pos = {cfg.top[COORD_W-1], cfg.top}
                   + {{(COORD_W+1-GLYPH_W){1'b0}}, row_reg};

    assign on_x = !x_pos[COORD_W]
                  && ({{(DIM_W-COORD_W){1'b0}}, x_pos[COORD_W-1:0]} < cfg.xres);
    assign on_y = !y_pos[COORD_W]
                  && ({{(DIM_W-COORD_W){1'b0}}, y_pos[COORD_W-1:0]} < cfg.yres);

    assign push        = accept && (coverage != '0) && on_x && on_y;
    assign push_data.x = x_pos[COORD_W-1:0];
    assign push_data.y = y_pos[COORD_W-1:0];

    assign col_inc = {1'b0, col_reg} + {{GLYPH_W{1'b0}}, 1'b1};
    assign row_inc = {1'b0, row_reg} + {{GLYPH_W{1'b0}}, 1'b1};

    // Wrap at or past the glyph size; a size of zero behaves as one
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= {1'b0, cfg.cols})
            begin
                col_next = '0;
                if (row_inc >= {1'b0, cfg.rows})
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_inc[GLYPH_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[GLYPH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gbbc_queue.sv
`default_nettype none

module gbbc_queue
    import gbbc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire pix_t  push_data,
    input  wire logic  pop,
    output pix_t       pop_data,
    output q_status_t  q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> rtl/gbbc_back.sv
`default_nettype none

module gbbc_back
    import gbbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire clip_cfg_t         cfg,
    input  wire q_status_t         q_stat,
    input  wire pix_t              pop_data,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [ADDR_W-1:0]      byte_address,
    output logic [DATA_W-1:0]      pixel_data,
    output logic [MODE_W-1:0]      access_size
);

    localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_16 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_32 = 2'd2;

    localparam int PROD_W = COORD_W + DIM_W;
    localparam int LIN_W  = PROD_W + 1;

    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]     addr_reg;
    logic [DATA_W-1:0]     data_reg;
    logic [MODE_W-1:0]     size_reg;
    logic                  load;
    logic [MODE_W-1:0]     mode_eff;
    logic [PROD_W-1:0]     prod;
    logic [LIN_W-1:0]      lin;
    logic [LIN_W-1:0]      shifted;
    logic [DATA_W-1:0]     data_next;

    assign load = !out_valid_reg || !out_stall;
    assign pop  = load && !q_stat.empty;

    always_comb
    begin
        case (cfg.mode)
            MODE_8:  mode_eff = MODE_8;
            MODE_16: mode_eff = MODE_16;
            default: mode_eff = MODE_32;
        endcase
    end

    assign prod    = PROD_W'(pop_data.y) * PROD_W'(cfg.xres);
    assign lin     = {1'b0, prod} + LIN_W'(pop_data.x);
    assign shifted = lin << mode_eff;

    // Pack RGB888 down to RGB565 at 16 bpp; low byte at 8 bpp, full word at 32 bpp
    always_comb
    begin
        case (mode_eff)
            MODE_8:  data_next = {24'd0, cfg.color[7:0]};
            MODE_16: data_next = {16'd0, cfg.color[23:19], cfg.color[15:10], cfg.color[7:3]};
            default: data_next = cfg.color;
        endcase
    end

    assign out_valid_next = load ? !q_stat.empty : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the word while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg <= shifted[ADDR_W-1:0];
            data_reg <= data_next;
            size_reg <= mode_eff;
        end
    end

    assign out_valid    = out_valid_reg;
    assign byte_address = addr_reg;
    assign pixel_data   = data_reg;
    assign access_size  = size_reg;

    a_align_16: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (size_reg == MODE_16)) |-> (addr_reg[0] == 1'b0))
        else $error("halfword write not aligned");

    a_align_32: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (size_reg == MODE_32)) |-> (addr_reg[1:0] == 2'b00))
        else $error("word write not aligned");

    a_size_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (size_reg != 2'd3))
        else $error("invalid access size");

endmodule

`default_nettype wire

>>> rtl/glyph_bitmap_blit_clip.sv
// Clipped glyph blit into a linear framebuffer at 8, 16 (RGB565) or 32 bpp.
// Input channel: one coverage byte per word (in_valid, in_stall, coverage),
// glyph bytes in row-major order. An internal column/row counter places each
// byte at (glyph_left + column, glyph_top + row).
// Output channel: one framebuffer write per nonzero, on-screen byte
// (out_valid, out_stall, byte_address, pixel_data, access_size). Off-screen
// and zero bytes are dropped but still advance the counters.
// Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
// Throughput: one input word per cycle while in_stall is low. A drawn pixel
// reaches the output through the queue and the output register: the front
// stage clips and queues it, the back stage does the y*xres multiply-add and
// color pack into the output register.
// A four-entry queue sits between front and back; when out_stall holds the
// output register, the queue fills and in_stall rises once it is full.
// Reset clears the counters, empties the queue and loads register defaults
// (size 1x1 glyph, 1x1 screen, 32 bpp, black).
`default_nettype none

module glyph_bitmap_blit_clip
    import gbbc_pkg::*;
#(
    parameter int MAX_SCREEN_DIM = DEF_MAX_SCREEN_DIM,
    parameter int MAX_GLYPH_DIM  = DEF_MAX_GLYPH_DIM
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [COVER_W-1:0]   coverage,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [ADDR_W-1:0]         byte_address,
    output logic [DATA_W-1:0]         pixel_data,
    output logic [MODE_W-1:0]         access_size
);

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_TOP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_XRES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_YRES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR  = 3'd7;

    localparam logic [DIM_W-1:0]   SCREEN_CAP = DIM_W'(MAX_SCREEN_DIM);
    localparam logic [GLYPH_W-1:0] GLYPH_CAP  = GLYPH_W'(MAX_GLYPH_DIM);

    logic [COORD_W-1:0] left_reg;
    logic [COORD_W-1:0] top_reg;
    logic [GLYPH_W-1:0] cols_reg;
    logic [GLYPH_W-1:0] rows_reg;
    logic [COORD_W-1:0] xres_reg;
    logic [COORD_W-1:0] yres_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [DATA_W-1:0]  color_reg;

    logic [DIM_W-1:0]   xres_ext;
    logic [DIM_W-1:0]   yres_ext;
    clip_cfg_t          cfg;
    q_status_t          q_stat;
    logic               push;
    pix_t               push_data;
    logic               pop;
    pix_t               pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            top_reg   <= '0;
            cols_reg  <= GLYPH_W'(1);
            rows_reg  <= GLYPH_W'(1);
            xres_reg  <= COORD_W'(1);
            yres_reg  <= COORD_W'(1);
            mode_reg  <= MODE_W'(2);
            color_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GLYPH_LEFT:  left_reg  <= cfg_data[COORD_W-1:0];
                REG_GLYPH_TOP:   top_reg   <= cfg_data[COORD_W-1:0];
                REG_GLYPH_COLS:  cols_reg  <= cfg_data[GLYPH_W-1:0];
                REG_GLYPH_ROWS:  rows_reg  <= cfg_data[GLYPH_W-1:0];
                REG_SCREEN_XRES: xres_reg  <= cfg_data[COORD_W-1:0];
                REG_SCREEN_YRES: yres_reg  <= cfg_data[COORD_W-1:0];
                REG_DEPTH_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                REG_DRAW_COLOR:  color_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign xres_ext = {{(DIM_W-COORD_W){1'b0}}, xres_reg};
    assign yres_ext = {{(DIM_W-COORD_W){1'b0}}, yres_reg};

    // Cap sizes to the supported maximum
    assign cfg.left  = $signed(left_reg);
    assign cfg.top   = $signed(top_reg);
    assign cfg.cols  = (cols_reg > GLYPH_CAP) ? GLYPH_CAP : cols_reg;
    assign cfg.rows  = (rows_reg > GLYPH_CAP) ? GLYPH_CAP : rows_reg;
    assign cfg.xres  = (xres_ext > SCREEN_CAP) ? SCREEN_CAP : xres_ext;
    assign cfg.yres  = (yres_ext > SCREEN_CAP) ? SCREEN_CAP : yres_ext;
    assign cfg.mode  = mode_reg;
    assign cfg.color = color_reg;

    gbbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .coverage  (coverage),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    gbbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    gbbc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_stat       (q_stat),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_address (byte_address),
        .pixel_data   (pixel_data),
        .access_size  (access_size)
    );

endmodule

`default_nettype wire

>>> bench/gbbc_tb_pkg.sv
`timescale 1ns / 100ps

package gbbc_tb_pkg;

    typedef enum logic [2:0] {
        REG_LEFT  = 3'd0,
        REG_TOP   = 3'd1,
        REG_COLS  = 3'd2,
        REG_ROWS  = 3'd3,
        REG_XRES  = 3'd4,
        REG_YRES  = 3'd5,
        REG_DEPTH = 3'd6,
        REG_COLOR = 3'd7
    } blit_reg_e;

    typedef enum logic [1:0] {
        DEPTH_8      = 2'd0,
        DEPTH_16     = 2'd1,
        DEPTH_32     = 2'd2,
        DEPTH_32_ALT = 2'd3
    } depth_e;

endpackage

>>> bench/blit_checker.sv
`timescale 1ns / 100ps

module blit_checker
    import gbbc_pkg::*;
    import gbbc_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [COVER_W-1:0]   coverage,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [ADDR_W-1:0]    byte_address,
    input  logic [DATA_W-1:0]    pixel_data,
    input  logic [MODE_W-1:0]    access_size,
    output int                   fail_count,
    output int                   writes_pending
);

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [MODE_W-1:0] size;
    } fb_write_t;

    fb_write_t fb_writes_q[$];

    logic [COORD_W-1:0] left_r;
    logic [COORD_W-1:0] top_r;
    logic [GLYPH_W-1:0] cols_r;
    logic [GLYPH_W-1:0] rows_r;
    logic [COORD_W-1:0] xres_r;
    logic [COORD_W-1:0] yres_r;
    logic [MODE_W-1:0]  mode_r;
    logic [DATA_W-1:0]  color_r;
    logic [GLYPH_W-1:0] col_pos;
    logic [GLYPH_W-1:0] row_pos;
    int                 fails;

    task automatic place_pixel(input logic [COVER_W-1:0] cov);
        int                x;
        int                y;
        int                xr;
        int                yr;
        longint            offs;
        logic [MODE_W-1:0] m;
        fb_write_t         w;

        xr = int'(xres_r);
        yr = int'(yres_r);
        if (xr > DEF_MAX_SCREEN_DIM)
            xr = DEF_MAX_SCREEN_DIM;
        if (yr > DEF_MAX_SCREEN_DIM)
            yr = DEF_MAX_SCREEN_DIM;
        x = $signed(left_r);
        x = x + int'(col_pos);
        y = $signed(top_r);
        y = y + int'(row_pos);

        if (cov != '0 && x >= 0 && y >= 0 && x < xr && y < yr) begin
            m = (mode_r == DEPTH_32_ALT) ? DEPTH_32 : mode_r;
            offs = (longint'(y) * xr + x) << m;
            w.addr = ADDR_W'(offs);
            case (m)
                DEPTH_8:  w.data = {24'b0, color_r[7:0]};
                DEPTH_16: w.data = {16'b0, color_r[23:19], color_r[15:10], color_r[7:3]};
                default:  w.data = color_r;
            endcase
            w.size = m;
            fb_writes_q.push_back(w);
        end

        // wrap also when a size was lowered below the current position
        if (int'(col_pos) + 1 >= int'(cols_r)) begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= int'(rows_r))
                row_pos = '0;
            else
                row_pos = row_pos + 1'b1;
        end
        else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    task automatic check_write();
        fb_write_t w;

        if (fb_writes_q.size() == 0) begin
            $error("framebuffer write with none expected: addr %h data %h size %0d",
                   byte_address, pixel_data, access_size);
            fails++;
        end
        else begin
            w = fb_writes_q.pop_front();
            if (byte_address !== w.addr) begin
                $error("byte_address: expected %h, got %h", w.addr, byte_address);
                fails++;
            end
            if (pixel_data !== w.data) begin
                $error("pixel_data: expected %h, got %h", w.data, pixel_data);
                fails++;
            end
            if (access_size !== w.size) begin
                $error("access_size: expected %0d, got %0d", w.size, access_size);
                fails++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_r   = '0;
            top_r    = '0;
            cols_r   = 8'd1;
            rows_r   = 8'd1;
            xres_r   = 13'd1;
            yres_r   = 13'd1;
            mode_r   = DEPTH_32;
            color_r  = '0;
            col_pos  = '0;
            row_pos  = '0;
            fb_writes_q.delete();
            writes_pending <= 0;
        end
        else begin
            if (out_valid && !out_stall)
                check_write();
            if (in_valid && !in_stall)
                place_pixel(coverage);
            if (cfg_write) begin
                case (cfg_index)
                    REG_LEFT:  left_r  = cfg_data[COORD_W-1:0];
                    REG_TOP:   top_r   = cfg_data[COORD_W-1:0];
                    REG_COLS:  cols_r  = cfg_data[GLYPH_W-1:0];
                    REG_ROWS:  rows_r  = cfg_data[GLYPH_W-1:0];
                    REG_XRES:  xres_r  = cfg_data[COORD_W-1:0];
                    REG_YRES:  yres_r  = cfg_data[COORD_W-1:0];
                    REG_DEPTH: mode_r  = cfg_data[MODE_W-1:0];
                    REG_COLOR: color_r = cfg_data;
                    default: ;
                endcase
            end
            writes_pending <= fb_writes_q.size();
        end
    end

    always @(*)
        fail_count = fails + fb_writes_q.size();

endmodule

>>> bench/tb_glyph_bitmap_blit_clip.sv
`timescale 1ns / 100ps

module tb_glyph_bitmap_blit_clip;
    import gbbc_pkg::*;
    import gbbc_tb_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [COVER_W-1:0]   coverage;
    logic                 out_valid;
    logic                 out_stall;
    logic [ADDR_W-1:0]    byte_address;
    logic [DATA_W-1:0]    pixel_data;
    logic [MODE_W-1:0]    access_size;
    int                   fail_count;
    int                   writes_pending;
    bit                   steady;

    glyph_bitmap_blit_clip dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .coverage     (coverage),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_address (byte_address),
        .pixel_data   (pixel_data),
        .access_size  (access_size)
    );

    blit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .coverage       (coverage),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .byte_address   (byte_address),
        .pixel_data     (pixel_data),
        .access_size    (access_size),
        .fail_count     (fail_count),
        .writes_pending (writes_pending)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        out_stall <= rst_n && !steady && ($urandom_range(99) < 15);

    task automatic send_cover(input logic [COVER_W-1:0] cov);
        while (!steady && $urandom_range(99) < 15) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        coverage <= cov;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop valid, wait out every pending write, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (writes_pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input blit_reg_e idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic setup_glyph(input int left, input int top, input int cols,
                               input int rows, input int xres, input int yres,
                               input int depth, input logic [DATA_W-1:0] color);
        write_reg(REG_LEFT, DATA_W'(left));
        write_reg(REG_TOP, DATA_W'(top));
        write_reg(REG_COLS, DATA_W'(cols));
        write_reg(REG_ROWS, DATA_W'(rows));
        write_reg(REG_XRES, DATA_W'(xres));
        write_reg(REG_YRES, DATA_W'(yres));
        write_reg(REG_DEPTH, DATA_W'(depth));
        write_reg(REG_COLOR, color);
        end_writes();
    endtask

    function automatic int pick_glyph_dim();
        case ($urandom_range(15))
            0:       return 255;
            1:       return 0;
            2, 3, 4: return $urandom_range(255);
            default: return $urandom_range(16, 1);
        endcase
    endfunction

    function automatic int pick_screen_dim();
        case ($urandom_range(15))
            0:       return 4096;
            1:       return 0;
            2:       return $urandom_range(8191, 4097);
            3, 4, 5: return $urandom_range(4095, 65);
            default: return $urandom_range(64, 1);
        endcase
    endfunction

    task automatic random_setup();
        int               cols;
        int               rows;
        int               xres;
        int               yres;
        int               xe;
        int               ye;
        int               left;
        int               top;
        logic [DATA_W-1:0] color;

        cols = pick_glyph_dim();
        rows = pick_glyph_dim();
        xres = pick_screen_dim();
        yres = pick_screen_dim();
        xe = (xres > 4096) ? 4096 : xres;
        ye = (yres > 4096) ? 4096 : yres;
        // mostly overlap the screen so that writes come often
        if ($urandom_range(9) < 7) begin
            left = int'($urandom_range(xe + cols)) - cols;
            top  = int'($urandom_range(ye + rows)) - rows;
        end
        else begin
            left = int'($urandom_range(8191)) - 4096;
            top  = int'($urandom_range(8191)) - 4096;
        end
        case ($urandom_range(9))
            0:       color = '0;
            1:       color = '1;
            default: color = $urandom;
        endcase
        setup_glyph(left, top, cols, rows, xres, yres, $urandom_range(3), color);
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        coverage  = '0;
        steady    = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset setup: one pixel screen, 32 bpp black
        send_cover(8'hFF);
        send_cover(8'h00);
        settle();

        // 3x3 glyph hanging off the top-left of a 2x2 screen, RGB565
        setup_glyph(-1, -1, 3, 3, 2, 2, DEPTH_16, 32'hFFFF_FFFF);
        send_cover(8'hFF);
        send_cover(8'h01);
        send_cover(8'h80);
        send_cover(8'h7F);
        send_cover(8'h00);
        send_cover(8'h55);
        send_cover(8'hAA);
        send_cover(8'h01);
        send_cover(8'hFE);
        settle();

        // last pixel of the largest screen, depth code three, zero glyph size
        setup_glyph(4095, 4095, 0, 0, 8191, 4096, DEPTH_32_ALT, 32'h89AB_CDEF);
        send_cover(8'h01);
        settle();
        write_reg(REG_DEPTH, DATA_W'(DEPTH_8));
        write_reg(REG_COLOR, 32'h0000_00A5);
        end_writes();
        send_cover(8'hFF);
        settle();
        write_reg(REG_XRES, 32'd0);
        end_writes();
        send_cover(8'hFF);
        settle();

        // shrink the glyph while the counters sit past the new size
        setup_glyph(0, 0, 2, 8, 16, 16, DEPTH_32, 32'h00F8_FC08);
        repeat (7) send_cover(8'h3C);
        settle();
        write_reg(REG_COLS, 32'd1);
        write_reg(REG_ROWS, 32'd2);
        end_writes();
        send_cover(8'hC3);
        send_cover(8'h10);
        send_cover(8'h02);
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            random_setup();
            steady = (phase == 2);
            for (int n = 0; n < 92; n++) begin
                if (phase == 5 && n == 40)
                    settle();
                if ($urandom_range(9) < 3)
                    send_cover('0);
                else
                    send_cover($urandom_range(255));
            end
            steady = 1'b0;
            settle();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/gbbc_pkg.sv
rtl/gbbc_front.sv
rtl/gbbc_queue.sv
rtl/gbbc_back.sv
rtl/glyph_bitmap_blit_clip.sv
bench/gbbc_tb_pkg.sv
bench/blit_checker.sv
bench/tb_glyph_bitmap_blit_clip.sv
